// File: rtl/frl_pkg.sv
// Shared types and constants for the framed link receiver.
// No dependencies.
package frl_pkg;

    localparam int MAX_INFO_BYTES = 260;
    localparam int INFO_W         = $clog2(MAX_INFO_BYTES + 2);

    localparam logic [7:0] ADDRESS_RESET = 8'h03;
    localparam logic [7:0] FLAG_RESET    = 8'h7e;
    localparam logic [7:0] PKT_DATA      = 8'd1;
    localparam logic [7:0] PKT_START     = 8'd2;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEADING = 3'd1,
        PH_CONTROL = 3'd2,
        PH_HCHECK  = 3'd3,
        PH_INFO    = 3'd4,
        PH_TRAILER = 3'd5
    } frl_phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } frl_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_HEADER   = 3'd1,
        ERR_DATA     = 3'd2,
        ERR_OVERFLOW = 3'd3,
        ERR_TRAILER  = 3'd4
    } frl_err_t;

    typedef enum logic {
        CFG_ADDRESS = 1'b0,
        CFG_FLAG    = 1'b1
    } frl_cfg_t;

    typedef struct packed {
        frl_kind_t   kind;
        logic [7:0]  payload_byte;
        frl_err_t    error_code;
        logic [7:0]  frame_control;
        logic        has_info;
        logic [7:0]  packet_control;
        logic [7:0]  sequence_number;
        logic [8:0]  payload_length;
        logic        size_valid;
        logic [31:0] file_size;
    } frl_result_t;

endpackage

// File: rtl/framed_link_receiver_top.sv
// Framed link receiver top level: configuration registers, parser and result register.
// Depends on frl_pkg, frl_parser and frl_result_reg.
//
// Usage:
//   Input channel: one received byte per word on rx_byte, in_valid/in_stall.
//   Output channel: one result word per out_valid/out_stall handshake; result_kind
//   says payload byte, frame accepted or frame rejected, the other fields as per kind.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 address, 1 flag) and
//   cfg_data; cfg_ready is always high. Write only while the block is idle.
//   Throughput: one byte per cycle while in_stall is low. Result timing: a byte
//   accepted at a clock edge shows its result, if any, at out_valid right after that
//   edge, set by the result register fed by the combinational parser.
//   Many bytes produce no result word.
//   Stall: in_stall rises while a result is held and out_stall is high; a held
//   result stays until taken.
//   Reset: address 0x03, flag 0x7e, parser hunting, result register empty.
module framed_link_receiver_top
    import frl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  payload_byte,
    output logic [2:0]  error_code,
    output logic [7:0]  frame_control,
    output logic        has_info,
    output logic [7:0]  packet_control,
    output logic [7:0]  sequence_number,
    output logic [8:0]  payload_length,
    output logic        size_valid,
    output logic [31:0] file_size,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0]  address_reg;
    logic [7:0]  flag_reg;
    logic        step;
    logic        res_valid;
    logic        busy;
    frl_result_t res;
    frl_result_t held;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign step      = in_valid && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg <= ADDRESS_RESET;
            flag_reg    <= FLAG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (frl_cfg_t'(cfg_index))
                CFG_ADDRESS: address_reg <= cfg_data;
                CFG_FLAG:    flag_reg    <= cfg_data;
                default:     ;
            endcase
        end
    end

    frl_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .rx_byte       (rx_byte),
        .address_value (address_reg),
        .flag_value    (flag_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    frl_result_reg u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .busy      (busy),
        .held      (held)
    );

    assign result_kind     = held.kind;
    assign payload_byte    = held.payload_byte;
    assign error_code      = held.error_code;
    assign frame_control   = held.frame_control;
    assign has_info        = held.has_info;
    assign packet_control  = held.packet_control;
    assign sequence_number = held.sequence_number;
    assign payload_length  = held.payload_length;
    assign size_valid      = held.size_valid;
    assign file_size       = held.file_size;

endmodule

// File: rtl/frl_parser.sv
// Frame parser: phase register, held header bytes and running check.
// Produces at most one result per byte. Depends on frl_pkg.
module frl_parser
    import frl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  address_value,
    input  logic [7:0]  flag_value,
    output logic        res_valid,
    output frl_result_t res
);

    frl_phase_t        phase_reg, phase_next;
    logic [7:0]        first_reg, first_next;
    logic              lead_reg, lead_next;
    logic [7:0]        ctl_reg, ctl_next;
    logic [INFO_W-1:0] idx_reg, idx_next;
    logic [7:0]        chk_reg, chk_next;
    logic [7:0]        pctl_reg, pctl_next;
    logic [7:0]        b2_reg, b2_next;
    logic [7:0]        b3_reg, b3_next;
    logic [7:0]        b4_reg, b4_next;
    logic              isctl_reg, isctl_next;
    logic [31:0]       acc_reg, acc_next;

    logic [7:0]  closer;
    logic        ctl_eff;
    logic        end_field;
    logic        clear;
    logic [15:0] idx16;

    always_comb
    begin
        phase_next = phase_reg;
        first_next = first_reg;
        lead_next  = lead_reg;
        ctl_next   = ctl_reg;
        idx_next   = idx_reg;
        chk_next   = chk_reg;
        pctl_next  = pctl_reg;
        b2_next    = b2_reg;
        b3_next    = b3_reg;
        b4_next    = b4_reg;
        isctl_next = isctl_reg;
        acc_next   = acc_reg;
        res        = '0;
        res_valid  = 1'b0;
        clear      = 1'b0;
        closer     = lead_reg ? first_reg : flag_value;
        ctl_eff    = isctl_reg || (idx_reg == INFO_W'(3) && pctl_reg != PKT_DATA);
        idx16      = 16'(idx_reg);
        end_field  = (!ctl_eff && idx_reg > INFO_W'(3) && {b3_reg, b4_reg} == idx16 - 16'd4)
                  || (ctl_eff && idx16 == 16'(b3_reg) + 16'd3);

        case (phase_reg)
            PH_HUNT:
            begin
                first_next = rx_byte;
                lead_next  = (rx_byte != address_value);
                phase_next = (rx_byte == address_value) ? PH_CONTROL : PH_LEADING;
            end
            PH_LEADING:
            begin
                if (rx_byte == address_value)
                    phase_next = PH_CONTROL;
            end
            PH_CONTROL:
            begin
                ctl_next   = rx_byte;
                phase_next = PH_HCHECK;
            end
            PH_HCHECK:
            begin
                if (rx_byte != (address_value ^ ctl_reg))
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_REJECT;
                    res.error_code = ERR_HEADER;
                    clear          = 1'b1;
                end
                else
                begin
                    idx_next   = '0;
                    chk_next   = '0;
                    isctl_next = 1'b0;
                    acc_next   = '0;
                    phase_next = PH_INFO;
                end
            end
            PH_INFO:
            begin
                if (rx_byte == closer && idx_reg == '0)
                begin
                    res_valid         = 1'b1;
                    res.kind          = KIND_ACCEPT;
                    res.frame_control = ctl_reg;
                    clear             = 1'b1;
                end
                else if (idx_reg > INFO_W'(MAX_INFO_BYTES))
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_REJECT;
                    res.error_code = ERR_OVERFLOW;
                    clear          = 1'b1;
                end
                else if (end_field)
                begin
                    isctl_next = ctl_eff;
                    if (rx_byte != chk_reg)
                    begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_REJECT;
                        res.error_code = ERR_DATA;
                        clear          = 1'b1;
                    end
                    else
                        phase_next = PH_TRAILER;
                end
                else
                begin
                    isctl_next = ctl_eff;
                    case (idx_reg)
                        INFO_W'(0): pctl_next = rx_byte;
                        INFO_W'(1): b2_next   = rx_byte;
                        INFO_W'(2): b3_next   = rx_byte;
                        INFO_W'(3): b4_next   = rx_byte;
                        default:    ;
                    endcase
                    if (ctl_eff && idx_reg >= INFO_W'(3))
                        acc_next = {acc_reg[23:0], rx_byte};
                    chk_next = chk_reg ^ rx_byte;
                    idx_next = idx_reg + INFO_W'(1);
                    if (!ctl_eff && idx_reg >= INFO_W'(4))
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_PAYLOAD;
                        res.payload_byte = rx_byte;
                    end
                end
            end
            PH_TRAILER:
            begin
                res_valid = 1'b1;
                clear     = 1'b1;
                if (rx_byte == first_reg || rx_byte == flag_value)
                begin
                    res.kind           = KIND_ACCEPT;
                    res.frame_control  = ctl_reg;
                    res.has_info       = 1'b1;
                    res.packet_control = pctl_reg;
                    if (pctl_reg == PKT_DATA)
                    begin
                        res.sequence_number = b2_reg;
                        res.payload_length  = {b3_reg[0], b4_reg};
                    end
                    else if (pctl_reg == PKT_START && b2_reg == 8'd0)
                    begin
                        res.size_valid = 1'b1;
                        res.file_size  = acc_reg;
                    end
                end
                else
                begin
                    res.kind       = KIND_REJECT;
                    res.error_code = ERR_TRAILER;
                end
            end
            default:
            begin
                clear = 1'b1;
            end
        endcase

        if (clear)
        begin
            phase_next = PH_HUNT;
            first_next = '0;
            lead_next  = 1'b0;
            ctl_next   = '0;
            idx_next   = '0;
            chk_next   = '0;
            pctl_next  = '0;
            b2_next    = '0;
            b3_next    = '0;
            b4_next    = '0;
            isctl_next = 1'b0;
            acc_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            first_reg <= '0;
            lead_reg  <= 1'b0;
            ctl_reg   <= '0;
            idx_reg   <= '0;
            chk_reg   <= '0;
            pctl_reg  <= '0;
            b2_reg    <= '0;
            b3_reg    <= '0;
            b4_reg    <= '0;
            isctl_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            first_reg <= first_next;
            lead_reg  <= lead_next;
            ctl_reg   <= ctl_next;
            idx_reg   <= idx_next;
            chk_reg   <= chk_next;
            pctl_reg  <= pctl_next;
            b2_reg    <= b2_next;
            b3_reg    <= b3_next;
            b4_reg    <= b4_next;
            isctl_reg <= isctl_next;
            acc_reg   <= acc_next;
        end
    end

    a_hunt_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (phase_reg == PH_HUNT || phase_reg == PH_LEADING)) |-> !res_valid)
        else $error("result produced while hunting");

    a_payload_in_info: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_PAYLOAD) |-> (phase_reg == PH_INFO && !ctl_eff))
        else $error("payload word outside a data packet field");

    a_close_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid && res.kind != KIND_PAYLOAD) |=> phase_reg == PH_HUNT)
        else $error("frame close did not return to hunting");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= INFO_W'(MAX_INFO_BYTES + 1))
        else $error("information index beyond bound");

endmodule

// File: rtl/frl_result_reg.sv
// Result holding register between the parser and the output channel.
// Depends on frl_pkg.
module frl_result_reg
    import frl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  frl_result_t res,
    input  logic        out_stall,
    output logic        out_valid,
    output logic        busy,
    output frl_result_t held
);

    logic        valid_reg, valid_next;
    frl_result_t data_reg;

    assign busy      = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign held      = data_reg;

    always_comb
    begin
        valid_next = valid_reg && out_stall;
        if (load)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

endmodule
